>>> rtl/core/pcmmix_pkg.sv
// Package: constants, types and helpers for the PCM mixer.
package pcmmix_pkg;
  localparam int unsigned CHANNEL_COUNT_DEF = 32;
  localparam int unsigned SAMPLE_DEPTH_DEF  = 65536;
  localparam logic [16:0] RATE_MIN = 17'd1000;
  localparam logic [16:0] RATE_MAX = 17'd96000;
  localparam logic [23:0] STEP_MAX = 24'hFFFFFF;

  typedef enum logic [2:0] {
    OP_MIX   = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_VOL   = 3'd3,
    OP_LOAD  = 3'd4
  } op_e;

  localparam logic REG_HOST_RATE = 1'b0;
  localparam logic REG_MIXER_EN  = 1'b1;

  // divider request / response
  typedef struct packed {
    logic        start;
    logic [16:0] rate;
    logic [17:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] step;
  } div_rsp_t;

  function automatic logic signed [16:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 17'sd32767;
    else if (v < -18'sd32768) return -17'sd32768;
    else return v[16:0];
  endfunction
endpackage

>>> rtl/core/pcmmix_div.sv
// Restoring divider: (rate << 16) / divisor, one quotient bit per cycle, saturated to 24 bits.
module pcmmix_div
  import pcmmix_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int unsigned NB = 33;

  logic [32:0] num_q, num_d;
  logic [18:0] rem_q, rem_d;
  logic [17:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [18:0] trial;
  logic [19:0] diff;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[17:0], num_q[32]};
    diff   = {1'b0, trial} - {2'b00, dvs_q};
    if (req_i.start) begin
      num_d  = {req_i.rate, 16'd0};
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'(NB);
      busy_d = (req_i.divisor != '0);
      done_d = (req_i.divisor == '0);
      if (req_i.divisor == '0) num_d = '1;
    end else if (busy_q) begin
      if (!diff[19]) begin
        rem_d = diff[18:0];
        num_d = {num_q[31:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.step = (num_q[32:24] != '0) ? STEP_MAX : num_q[23:0];
endmodule

>>> rtl/core/multichannel_pcm_sound_mixer.sv
// Top level of the multichannel PCM mixer.
// Usage:
//  s_axis: one command per transfer (mix, start, stop, volume, load byte).
//  m_axis: exactly one result per command: mixed frame, accepted, mask.
//  cfg: write channel, index 0 host sample rate, 1 mixer_enable; write while idle.
// Sequencing (states between the input transfer and the result in S_OUT):
//  load, stop, unknown opcode, rejected start, mix while disabled: S_DIV.
//  volume: S_DIV twice when accepted (waits for the vol*s product), else once.
//  start: S_DIV until the bit-serial step divider is done (33 quotient bits;
//  none when the host rate is zero).
//  mix: S_DIV, then S_RD, S_MUL, S_ACC per channel slot (memory read, multiply,
//  accumulate) over CHANNEL_COUNT slots; the multiply/saturate unit is shared
//  across the slots.
//  s_axis_tready drops at the input transfer and rises again the cycle after
//  the result transfer, so a new command waits until the last result is taken.
// Reset clears all channel state and the playing mask; the sample store is
// not cleared and must be written before it is read.
// A stalled receiver holds the result in the output register; the next
// command waits until it is taken.
module multichannel_pcm_sound_mixer
  import pcmmix_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF,
  parameter int unsigned SAMPLE_DEPTH  = SAMPLE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[2:0], channel[7:3], volume[14:8], separation[22:15], sound_base[38:23],
  // sound_length[54:39], sound_rate[71:55], sample_address[87:72],
  // sample_byte[95:88], music_left[111:96], music_right[127:112]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mix_left[15:0], mix_right[31:16], accepted[32], active_mask[64:33]
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [17:0]  cfg_data_i
);
  localparam int unsigned CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_RD   = 6'b000100,
    S_MUL  = 6'b001000,
    S_ACC  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [17:0] rate_cfg_q;
  logic        en_q;

  // latched command
  logic [127:0] cmd_q;
  logic [2:0]  op;
  logic [4:0]  ch_in;
  logic [6:0]  vol_in;
  logic [7:0]  sep_in;
  logic [15:0] base_in, len_in, addr_in;
  logic [16:0] srate_in;
  logic [7:0]  byte_in;
  assign op       = cmd_q[2:0];
  assign ch_in    = cmd_q[7:3];
  assign vol_in   = cmd_q[14:8];
  assign sep_in   = cmd_q[22:15];
  assign base_in  = cmd_q[38:23];
  assign len_in   = cmd_q[54:39];
  assign srate_in = cmd_q[71:55];
  assign addr_in  = cmd_q[87:72];
  assign byte_in  = cmd_q[95:88];

  logic [31:0] pos_q   [CHANNEL_COUNT];
  logic [23:0] step_q  [CHANNEL_COUNT];
  logic [6:0]  lg_q    [CHANNEL_COUNT];
  logic [6:0]  rg_q    [CHANNEL_COUNT];
  logic [15:0] cbase_q [CHANNEL_COUNT];
  logic [15:0] clen_q  [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] play_q;

  logic [7:0] store [SAMPLE_DEPTH];
  logic [7:0] rd_q;

  logic [CW-1:0] ci_q;
  logic [5:0]    ph_q; // cycles spent in S_DIV
  logic signed [16:0] accl_q, accr_q;
  logic signed [25:0] pl_q, pr_q;
  logic          skip_q;
  logic          ok_q;

  logic ch_ok;
  assign ch_ok = 32'(ch_in) < CHANNEL_COUNT;
  logic [CW-1:0] chx;
  assign chx = ch_in[CW-1:0];

  // gain curve on a registered vol*s product: vol*s*s >> 16
  logic [8:0]  s_l, s_r;
  logic [24:0] cut_l, cut_r;
  logic [6:0]  g_l, g_r;
  logic [15:0] vs_l_q, vs_r_q;
  assign s_l = {1'b0, sep_in} + 9'd1;
  assign s_r = 9'd257 - s_l;
  assign cut_l = vs_l_q * s_l;
  assign cut_r = vs_r_q * s_r;
  assign g_l = (cut_l[24:16] > {2'b0, vol_in}) ? 7'd0 : vol_in - cut_l[22:16];
  assign g_r = (cut_r[24:16] > {2'b0, vol_in}) ? 7'd0 : vol_in - cut_r[22:16];

  div_req_t dreq;
  div_rsp_t drsp;
  pcmmix_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  logic [AW-1:0] rd_addr;
  assign rd_addr = AW'(cbase_q[ci_q] + pos_q[ci_q][31:16]);

  logic signed [8:0]  smp;
  logic signed [16:0] smpw;
  assign smp  = $signed({1'b0, rd_q}) - 9'sd128;
  assign smpw = {smp, 8'd0};

  logic signed [17:0] suml, sumr;
  assign suml = {accl_q[16], accl_q} + 18'(pl_q >>> 7);
  assign sumr = {accr_q[16], accr_q} + 18'(pr_q >>> 7);

  logic last_ch;
  assign last_ch = (32'(ci_q) == CHANNEL_COUNT - 1);
  logic rate_ok;
  assign rate_ok = srate_in >= RATE_MIN && srate_in <= RATE_MAX;

  always_comb begin
    dreq.start   = 1'b0;
    dreq.rate    = srate_in;
    dreq.divisor = rate_cfg_q;
    state_d = state_q;
    case (state_q)
      S_IDLE: if (acc_in) state_d = S_DIV;
      S_DIV: begin
        if (op == OP_START && en_q && ch_ok && rate_ok) begin
          if (ph_q == 6'd0) dreq.start = 1'b1;
          if (drsp.done) state_d = S_OUT;
        end else if (op == OP_MIX && en_q) begin
          state_d = S_RD;
        end else if (op == OP_VOL && ch_ok && play_q[chx] && ph_q == 6'd0) begin
          // volume update waits for the registered vol*s product
          state_d = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RD:  state_d = S_MUL;
      S_MUL: state_d = S_ACC;
      S_ACC: state_d = last_ch ? S_OUT : S_RD;
      S_OUT: if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rate_cfg_q <= 18'd44100;
      en_q <= 1'b0;
      play_q <= '0;
      ph_q <= '0;
      ci_q <= '0;
      ok_q <= 1'b0;
      skip_q <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        pos_q[i] <= '0; step_q[i] <= '0; lg_q[i] <= '0; rg_q[i] <= '0;
        cbase_q[i] <= '0; clen_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_HOST_RATE) rate_cfg_q <= cfg_data_i;
        else en_q <= cfg_data_i[0];
      end
      case (state_q)
        S_IDLE: begin
          ph_q <= '0;
          ci_q <= '0;
        end
        S_DIV: begin
          ph_q <= ph_q + 6'd1;
          case (op)
            OP_MIX: ok_q <= 1'b1;
            OP_START: begin
              ok_q <= en_q && ch_ok && rate_ok && drsp.done;
              if (en_q && ch_ok && rate_ok && drsp.done) begin
                cbase_q[chx] <= base_in;
                clen_q[chx]  <= len_in;
                pos_q[chx]   <= '0;
                step_q[chx]  <= drsp.step;
                lg_q[chx]    <= g_l;
                rg_q[chx]    <= g_r;
                play_q[chx]  <= 1'b1;
              end
            end
            OP_STOP: begin
              ok_q <= ch_ok;
              if (ch_ok) play_q[chx] <= 1'b0;
            end
            OP_VOL: begin
              ok_q <= ch_ok && play_q[chx] && ph_q != 6'd0;
              if (ch_ok && play_q[chx] && ph_q != 6'd0) begin
                lg_q[chx] <= g_l;
                rg_q[chx] <= g_r;
              end
            end
            OP_LOAD: ok_q <= 1'b1;
            default: ok_q <= 1'b0;
          endcase
        end
        S_RD: begin
          skip_q <= !play_q[ci_q] || (pos_q[ci_q] >= {clen_q[ci_q], 16'd0});
          if (play_q[ci_q] && pos_q[ci_q] >= {clen_q[ci_q], 16'd0}) begin
            play_q[ci_q] <= 1'b0;
          end else if (play_q[ci_q]) begin
            pos_q[ci_q] <= pos_q[ci_q] + 32'(step_q[ci_q]);
          end
        end
        S_ACC: ci_q <= ci_q + CW'(1);
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    vs_l_q <= vol_in * s_l;
    vs_r_q <= vol_in * s_r;
    if (acc_in) cmd_q <= s_axis_tdata;
    if (state_q == S_RD) rd_q <= store[rd_addr];
    if (state_q == S_IDLE && acc_in) begin
      accl_q <= {s_axis_tdata[111], s_axis_tdata[111:96]};
      accr_q <= {s_axis_tdata[127], s_axis_tdata[127:112]};
    end
    if (state_q == S_DIV && op == OP_LOAD && ph_q == 6'd0)
      store[AW'(addr_in)] <= byte_in;
    if (state_q == S_MUL) begin
      pl_q <= smpw * $signed({1'b0, lg_q[ci_q]});
      pr_q <= smpw * $signed({1'b0, rg_q[ci_q]});
    end
    if (state_q == S_ACC && !skip_q) begin
      accl_q <= sat16(suml);
      accr_q <= sat16(sumr);
    end
  end

  logic is_mix;
  assign is_mix = (op == OP_MIX);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {7'd0, 32'(play_q), ok_q,
                         is_mix ? accr_q[15:0] : 16'd0,
                         is_mix ? accl_q[15:0] : 16'd0};
endmodule

>>> rtl/core/pcmmix_checker.sv
// Port-level checker for the PCM mixer, bound to the top level.
module pcmmix_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:65] == 7'd0) else $error("pad bits set");
endmodule

bind multichannel_pcm_sound_mixer pcmmix_checker u_chk (.*);

>>> bench/tb_top.sv
// Testbench for the multichannel PCM mixer: streamed commands checked against a local predictor.
`timescale 1ns / 100ps

module tb_top
  import pcmmix_pkg::*;
();

  // One command as it travels on the slave stream.
  typedef struct {
    logic [2:0]  opcode;
    logic [4:0]  channel;
    logic [6:0]  volume;
    logic [7:0]  separation;
    logic [15:0] base;
    logic [15:0] length;
    logic [16:0] rate;
    logic [15:0] address;
    logic [7:0]  sample;
    logic [15:0] music_l;
    logic [15:0] music_r;
  } command_t;

  // One frame or status result.
  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        accepted;
    logic [31:0] mask;
  } frame_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // opcode, channel, volume, separation, sound_base, sound_length, sound_rate,
  // sample_address, sample_byte, music_left, music_right
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // mix_left, mix_right, accepted, active_mask
  logic [71:0]  m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_index_i = 1'b0;
  logic [17:0]  cfg_data_i = '0;

  always #6 clk_i = ~clk_i;

  multichannel_pcm_sound_mixer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // ---------------------------------------------------------------- predictor state
  logic [7:0]  store_q [int];
  logic [31:0] pos_q [32];
  logic [23:0] step_q [32];
  logic [6:0]  gain_l_q [32];
  logic [6:0]  gain_r_q [32];
  logic [15:0] base_q [32];
  logic [15:0] len_q [32];
  logic [31:0] playing_q;
  logic [17:0] out_rate_q;
  logic        enable_q;

  command_t pending_cmds[$];
  frame_t   expected_frames[$];
  int       errors = 0;
  bit       calm = 1'b0;   // no idling on either side while set

  function automatic logic [6:0] curve_gain(int unsigned vol, int unsigned s);
    int unsigned cut;
    cut = (vol * s * s) >> 16;
    return (cut > vol) ? 7'd0 : 7'(vol - cut);
  endfunction

  function automatic int shr7_floor(int p);
    return p >>> 7;
  endfunction

  function automatic int clip16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  // Works out the frame a command yields and advances the channel state.
  function automatic frame_t mix_predict(command_t c);
    frame_t r;
    int l, rr, smp;
    logic [31:0] p;
    logic [15:0] a;
    longint unsigned q;
    r.accepted = 1'b0;
    l = 0;
    rr = 0;
    case (op_e'(c.opcode))
      OP_MIX: begin
        l = $signed(c.music_l);
        rr = $signed(c.music_r);
        r.accepted = 1'b1;
        if (enable_q)
          for (int ch = 0; ch < 32; ch++) begin
            if (!playing_q[ch]) continue;
            p = pos_q[ch];
            if (p >= {len_q[ch], 16'h0}) begin
              playing_q[ch] = 1'b0;
              continue;
            end
            a = base_q[ch] + p[31:16];
            smp = (int'(store_q[a]) - 128) * 256;
            pos_q[ch] = p + step_q[ch];
            l = clip16(l + shr7_floor(smp * int'(gain_l_q[ch])));
            rr = clip16(rr + shr7_floor(smp * int'(gain_r_q[ch])));
          end
      end
      OP_START: begin
        if (enable_q && c.rate >= RATE_MIN && c.rate <= RATE_MAX) begin
          q = STEP_MAX;
          if (out_rate_q != 0) begin
            q = (longint'(c.rate) << 16) / out_rate_q;
            if (q > STEP_MAX) q = STEP_MAX;
          end
          base_q[c.channel] = c.base;
          len_q[c.channel] = c.length;
          pos_q[c.channel] = '0;
          step_q[c.channel] = 24'(q);
          gain_l_q[c.channel] = curve_gain(c.volume, c.separation + 1);
          gain_r_q[c.channel] = curve_gain(c.volume, 256 - c.separation);
          playing_q[c.channel] = 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_STOP: begin
        playing_q[c.channel] = 1'b0;
        r.accepted = 1'b1;
      end
      OP_VOL: begin
        if (playing_q[c.channel]) begin
          gain_l_q[c.channel] = curve_gain(c.volume, c.separation + 1);
          gain_r_q[c.channel] = curve_gain(c.volume, 256 - c.separation);
          r.accepted = 1'b1;
        end
      end
      OP_LOAD: begin
        store_q[c.address] = c.sample;
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    r.left = 16'(l);
    r.right = 16'(rr);
    r.mask = playing_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
          command_t c;
          c = pending_cmds.pop_front();
          expected_frames.push_back(mix_predict(c));
          s_axis_tdata <= {c.music_r, c.music_l, c.sample, c.address, c.rate, c.length,
                           c.base, c.separation, c.volume, c.channel, c.opcode};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm || $urandom_range(99) >= 24;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        $display("unexpected result %h at %0t", m_axis_tdata, $time);
        errors++;
      end else begin
        frame_t e;
        e = expected_frames.pop_front();
        if (m_axis_tdata[15:0] !== e.left) report_mismatch("mix_left", m_axis_tdata[15:0], e.left);
        if (m_axis_tdata[31:16] !== e.right)
          report_mismatch("mix_right", m_axis_tdata[31:16], e.right);
        if (m_axis_tdata[32] !== e.accepted)
          report_mismatch("accepted", m_axis_tdata[32], e.accepted);
        if (m_axis_tdata[64:33] !== e.mask)
          report_mismatch("active_mask", m_axis_tdata[64:33], e.mask);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic command_t blank_cmd(logic [2:0] op);
    command_t c;
    c.opcode = op;
    c.channel = 5'($urandom);
    c.volume = 7'($urandom);
    c.separation = 8'($urandom_range(254));
    c.base = 16'($urandom);
    c.length = 16'($urandom);
    c.rate = 17'($urandom_range(96000, 1000));
    c.address = 16'($urandom);
    c.sample = 8'($urandom);
    c.music_l = 16'($urandom);
    c.music_r = 16'($urandom);
    return c;
  endfunction

  // A start that only reads bytes already loaded, in a short window at region*64.
  function automatic command_t start_cmd(int region);
    command_t c;
    c = blank_cmd(OP_START);
    c.base = 16'(region * 64);
    c.length = 16'($urandom_range(40));
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_frames.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [17:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_HOST_RATE) out_rate_q = val;
    else enable_q = val[0];
  endtask

  initial begin
    command_t c;
    int n;
    playing_q = '0;
    out_rate_q = 18'd44100;
    enable_q = 1'b0;
    for (int i = 0; i < 32; i++) begin
      pos_q[i] = '0; step_q[i] = '0; gain_l_q[i] = '0; gain_r_q[i] = '0;
      base_q[i] = '0; len_q[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill 256 bytes (4 regions of 64, windows of up to 40 bytes), plus
    // the top of the store so wrap-around reads are defined.
    for (int a = 0; a < 256; a++) begin
      c = blank_cmd(OP_LOAD);
      c.address = 16'(a);
      c.sample = (a < 4) ? 8'(a * 85) : 8'($urandom);
      pending_cmds.push_back(c);
    end
    for (int a = 65504; a < 65536; a++) begin
      c = blank_cmd(OP_LOAD);
      c.address = 16'(a);
      pending_cmds.push_back(c);
    end
    wait_drained();

    // Directed: disabled behaviour first, then extremes.
    c = start_cmd(0); pending_cmds.push_back(c);          // rejected while disabled
    c = blank_cmd(OP_MIX); c.music_l = 16'h8000; c.music_r = 16'h7fff;
    pending_cmds.push_back(c);                             // pass through
    c = blank_cmd(3'd5); pending_cmds.push_back(c);
    c = blank_cmd(3'd7); pending_cmds.push_back(c);
    wait_drained();
    write_reg(REG_MIXER_EN, 18'd1);
    write_reg(REG_HOST_RATE, 18'd1000);
    c = start_cmd(1); c.rate = 17'd999; pending_cmds.push_back(c);    // rate too low
    c = start_cmd(1); c.rate = 17'd96001; pending_cmds.push_back(c);  // rate too high
    c = start_cmd(1); c.channel = 5'd0; c.rate = 17'd96000; c.volume = 7'd127;
    c.separation = 8'd0; pending_cmds.push_back(c);
    c = start_cmd(2); c.channel = 5'd31; c.rate = 17'd1000; c.volume = 7'd127;
    c.separation = 8'd254; c.length = 16'd4; pending_cmds.push_back(c);
    c = start_cmd(3); c.channel = 5'd5; c.length = 16'd0; pending_cmds.push_back(c);
    c = blank_cmd(OP_START); c.channel = 5'd6; c.base = 16'hfff0; c.length = 16'd30;
    c.rate = 17'd1000; pending_cmds.push_back(c);          // wraps across the store end
    c = blank_cmd(OP_VOL); c.channel = 5'd9; pending_cmds.push_back(c);  // idle channel
    c = blank_cmd(OP_VOL); c.channel = 5'd31; c.volume = 7'd0; pending_cmds.push_back(c);
    for (int i = 0; i < 4; i++) begin
      c = blank_cmd(OP_MIX); c.music_l = (i & 1) ? 16'h7fff : 16'h8000;
      c.music_r = ~c.music_l; pending_cmds.push_back(c);
    end
    c = blank_cmd(OP_STOP); c.channel = 5'd0; pending_cmds.push_back(c);
    c = blank_cmd(OP_MIX); pending_cmds.push_back(c);
    wait_drained();

    // Random phases over several register settings.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_reg(REG_HOST_RATE, 18'd44100);
        1: write_reg(REG_HOST_RATE, 18'd192000);
        2: write_reg(REG_HOST_RATE, 18'd0);              // step saturates
        3: write_reg(REG_HOST_RATE, 18'h3ffff);
        default: begin
          write_reg(REG_HOST_RATE, 18'($urandom_range(192000, 1000)));
          write_reg(REG_MIXER_EN, 18'd0);
        end
      endcase
      calm = (ph == 1);
      for (int i = 0; i < 90; i++) begin
        n = $urandom_range(99);
        if (n < 35) c = blank_cmd(OP_MIX);
        else if (n < 65) c = start_cmd($urandom_range(3));
        else if (n < 75) c = blank_cmd(OP_STOP);
        else if (n < 85) c = blank_cmd(OP_VOL);
        else if (n < 95) begin
          c = blank_cmd(OP_LOAD); c.address = 16'($urandom_range(255));
        end else begin
          c = blank_cmd(3'($urandom_range(7, 5)));
        end
        if (n >= 35 && n < 65 && $urandom_range(9) == 0) c.rate = 17'($urandom);
        pending_cmds.push_back(c);
      end
      wait_drained();
      calm = 1'b0;
      if (ph == 4) write_reg(REG_MIXER_EN, 18'd1);
    end

    if (errors == 0) begin
      $display("multichannel_pcm_sound_mixer verification clean");
    end else begin
      $display("multichannel_pcm_sound_mixer verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("multichannel_pcm_sound_mixer verification failed");
    $finish;
  end

endmodule
